[rtl/core/sbc_pkg.sv]
// Shared types and constants for the sphere-box contact pipeline.
package sbc_pkg;

  localparam int unsigned SQRT_STAGES = 30;
  localparam int unsigned DIV_STAGES  = 15;
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned LATENCY = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;
  localparam logic [14:0] NORMAL_ONE = 15'd16384;

  typedef struct packed {
    logic [47:0] box_max_offset;
    logic [47:0] box_min_offset;
    logic [47:0] box_position;
    logic [15:0] sphere_radius;
    logic [47:0] sphere_center;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] contact_point;
    logic [47:0] contact_normal;
    logic [15:0] penetration_depth;
  } out_t;

  // Sideband that travels with each word down the pipe.
  typedef struct packed {
    logic             hit;
    logic             zero;
    logic [15:0]      radius;
    logic [47:0]      center;
    logic [47:0]      point;
    logic [2:0]       neg;
    logic [2:0][15:0] dabs;
    logic [31:0]      dist2;
  } ctx_t;

endpackage

[rtl/core/sbc_front.sv]
// Clamp, delta, squares and hit compare: four register stages.
module sbc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  sbc_pkg::in_t  data_in,
  output logic          vld_out,
  output sbc_pkg::ctx_t ctx_out
);

  logic [3:0] vld_r;

  // stage 1
  logic signed [2:0][16:0] c1_r, q1_r;
  logic signed [2:0][16:0] q1_nxt;
  logic [15:0]             rad1_r;
  // stage 2
  logic [2:0][17:0] abs2_r, abs2_nxt;
  logic [2:0]       neg2_r, neg2_nxt;
  logic [47:0]      pt2_r, pt2_nxt;
  logic [47:0]      cen2_r;
  logic [15:0]      rad2_r;
  // stage 3
  logic [2:0][35:0] sq3_r;
  logic [31:0]      r2_3_r;
  logic [2:0][15:0] dabs3_r;
  logic [2:0]       neg3_r;
  logic [47:0]      pt3_r, cen3_r;
  logic [15:0]      rad3_r;
  // stage 4
  sbc_pkg::ctx_t ctx4_r, ctx4_nxt;

  always_comb begin
    logic signed [16:0] c, lo, hi, q;
    for (int k = 0; k < 3; k++) begin
      c  = 17'($signed(data_in.sphere_center[16*k +: 16]));
      lo = 17'($signed(data_in.box_position[16*k +: 16]))
         + 17'($signed(data_in.box_min_offset[16*k +: 16]));
      hi = 17'($signed(data_in.box_position[16*k +: 16]))
         + 17'($signed(data_in.box_max_offset[16*k +: 16]));
      q = (c < lo) ? lo : c;
      if (q > hi) q = hi;
      q1_nxt[k] = q;
    end
  end

  always_comb begin
    logic signed [17:0] d;
    logic signed [16:0] q;
    for (int k = 0; k < 3; k++) begin
      q = q1_r[k];
      d = 18'($signed(c1_r[k])) - 18'(q);
      neg2_nxt[k] = d[17];
      abs2_nxt[k] = d[17] ? 18'(-d) : 18'(d);
      if (q > 17'sd32767)       pt2_nxt[16*k +: 16] = 16'h7fff;
      else if (q < -17'sd32768) pt2_nxt[16*k +: 16] = 16'h8000;
      else                      pt2_nxt[16*k +: 16] = q[15:0];
    end
  end

  always_comb begin
    logic [35:0] sum;
    sum = sq3_r[0] + sq3_r[1] + sq3_r[2];
    ctx4_nxt.hit    = sum <= {4'd0, r2_3_r};
    ctx4_nxt.zero   = sum == 36'd0;
    ctx4_nxt.radius = rad3_r;
    ctx4_nxt.center = cen3_r;
    ctx4_nxt.point  = pt3_r;
    ctx4_nxt.neg    = neg3_r;
    ctx4_nxt.dabs   = dabs3_r;
    ctx4_nxt.dist2  = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      c1_r[k]    <= 17'($signed(data_in.sphere_center[16*k +: 16]));
      sq3_r[k]   <= 36'(abs2_r[k]) * 36'(abs2_r[k]);
      dabs3_r[k] <= abs2_r[k][15:0];
    end
    q1_r    <= q1_nxt;
    rad1_r  <= data_in.sphere_radius;
    abs2_r  <= abs2_nxt;
    neg2_r  <= neg2_nxt;
    pt2_r   <= pt2_nxt;
    cen2_r  <= {c1_r[2][15:0], c1_r[1][15:0], c1_r[0][15:0]};
    rad2_r  <= rad1_r;
    r2_3_r  <= 32'(rad2_r) * 32'(rad2_r);
    neg3_r  <= neg2_r;
    pt3_r   <= pt2_r;
    cen3_r  <= cen2_r;
    rad3_r  <= rad2_r;
    ctx4_r  <= ctx4_nxt;
  end

  assign vld_out = vld_r[3];
  assign ctx_out = ctx4_r;

endmodule

[rtl/core/sbc_sqrt.sv]
// Pipelined integer square root of dist2 * 2^28, one root bit a stage.
module sbc_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  sbc_pkg::ctx_t ctx_in,
  output logic          vld_out,
  output sbc_pkg::ctx_t ctx_out,
  output logic [29:0]   root_out
);

  localparam int unsigned N = sbc_pkg::SQRT_STAGES;

  logic [N-1:0]       vld_r;
  sbc_pkg::ctx_t      ctx_r  [N];
  logic [32:0]        rem_r  [N];
  logic [29:0]        root_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], vld_in};
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [32:0]   rem_in, rem_nxt, trial;
    logic [29:0]   root_in, root_nxt;
    sbc_pkg::ctx_t cin;
    logic [59:0]   x;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign cin     = ctx_in;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign cin     = ctx_r[j-1];
    end

    always_comb begin
      logic [32:0] r;
      x       = {cin.dist2, 28'd0};
      r       = {rem_in[30:0], x[59-2*j -: 2]};
      trial   = {1'b0, root_in, 2'b01};
      if (r >= trial) begin
        rem_nxt  = r - trial;
        root_nxt = {root_in[28:0], 1'b1};
      end else begin
        rem_nxt  = r;
        root_nxt = {root_in[28:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      root_r[j] <= root_nxt;
      ctx_r[j]  <= cin;
    end
  end

  assign vld_out  = vld_r[N-1];
  assign ctx_out  = ctx_r[N-1];
  assign root_out = root_r[N-1];

endmodule

[rtl/core/sbc_div.sv]
// Pipelined restoring divide of |delta| * 2^28 by the root, three lanes.
module sbc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_in,
  input  sbc_pkg::ctx_t    ctx_in,
  input  logic [29:0]      root_in,
  output logic             vld_out,
  output sbc_pkg::ctx_t    ctx_out,
  output logic [29:0]      root_out,
  output logic [2:0][14:0] quo_out
);

  localparam int unsigned N = sbc_pkg::DIV_STAGES;

  logic [N-1:0]     vld_r;
  sbc_pkg::ctx_t    ctx_r  [N];
  logic [29:0]      root_r [N];
  logic [2:0][43:0] rem_r  [N];
  logic [2:0][14:0] quo_r  [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], vld_in};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    sbc_pkg::ctx_t    cin;
    logic [29:0]      din;
    logic [2:0][43:0] rin, rnxt;
    logic [2:0][14:0] qin, qnxt;
    logic [43:0]      dsh;

    if (i == 0) begin : g_first
      assign cin = ctx_in;
      assign din = root_in;
      assign rin = {{ctx_in.dabs[2], 28'd0}, {ctx_in.dabs[1], 28'd0},
                    {ctx_in.dabs[0], 28'd0}};
      assign qin = '0;
    end else begin : g_next
      assign cin = ctx_r[i-1];
      assign din = root_r[i-1];
      assign rin = rem_r[i-1];
      assign qin = quo_r[i-1];
    end

    assign dsh = 44'(din) << (N - 1 - i);

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        qnxt[k] = qin[k];
        rnxt[k] = rin[k];
        if (rin[k] >= dsh) begin
          rnxt[k] = rin[k] - dsh;
          qnxt[k][N-1-i] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      ctx_r[i]  <= cin;
      root_r[i] <= din;
      rem_r[i]  <= rnxt;
      quo_r[i]  <= qnxt;
    end
  end

  assign vld_out  = vld_r[N-1];
  assign ctx_out  = ctx_r[N-1];
  assign root_out = root_r[N-1];
  assign quo_out  = quo_r[N-1];

endmodule

[rtl/core/sphere_box_contact.sv]
// Sphere versus axis-aligned box contact: fully pipelined, one pair per cycle,
// with the path from start to out_valid made of 4 front stages for
// clamp, squares and compare, 30 square-root stages, 15 divide stages and
// the output register. busy is high only during reset, so a new word may be
// started on every cycle; each result shows for one cycle and must be taken
// then, as there is no way to hold it.
module sphere_box_contact (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  sbc_pkg::in_t in_data,
  output logic         out_valid,
  output sbc_pkg::out_t out_data
);

  logic             busy_r;
  logic             acc;
  logic             f_vld, s_vld, d_vld;
  sbc_pkg::ctx_t    f_ctx, s_ctx, d_ctx;
  logic [29:0]      s_root, d_root;
  logic [2:0][14:0] quo;
  logic             out_valid_r;
  sbc_pkg::out_t    out_data_r, out_data_nxt;

  assign acc = start && !busy_r;

  sbc_front u_front (
    .clk(clk), .rst_n(rst_n), .vld_in(acc), .data_in(in_data),
    .vld_out(f_vld), .ctx_out(f_ctx)
  );

  sbc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .vld_in(f_vld), .ctx_in(f_ctx),
    .vld_out(s_vld), .ctx_out(s_ctx), .root_out(s_root)
  );

  sbc_div u_div (
    .clk(clk), .rst_n(rst_n), .vld_in(s_vld), .ctx_in(s_ctx), .root_in(s_root),
    .vld_out(d_vld), .ctx_out(d_ctx), .root_out(d_root), .quo_out(quo)
  );

  always_comb begin
    logic [14:0] mag;
    mag = '0;
    out_data_nxt = '0;
    if (d_ctx.hit) begin
      out_data_nxt.hit = 1'b1;
      if (d_ctx.zero) begin
        out_data_nxt.contact_point     = d_ctx.center;
        out_data_nxt.contact_normal    = {32'd0, 1'b0, sbc_pkg::NORMAL_ONE};
        out_data_nxt.penetration_depth = d_ctx.radius;
      end else begin
        out_data_nxt.contact_point     = d_ctx.point;
        out_data_nxt.penetration_depth = d_ctx.radius - d_root[29:14];
        for (int k = 0; k < 3; k++) begin
          mag = (quo[k] > sbc_pkg::NORMAL_ONE) ? sbc_pkg::NORMAL_ONE : quo[k];
          out_data_nxt.contact_normal[16*k +: 16] =
            d_ctx.neg[k] ? 16'(-{1'b0, mag}) : {1'b0, mag};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/sbc_chk.sv]
// Port-level checker for the sphere-box contact block, with its bind.
module sbc_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input sbc_pkg::out_t out_data
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##50 out_valid)
    else $error("result word missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 50))
    else $error("result word without a started word");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |->
      (out_data.contact_point == 48'd0 && out_data.contact_normal == 48'd0 &&
       out_data.penetration_depth == 16'd0))
    else $error("miss word carries non-zero contact");

endmodule

bind sphere_box_contact sbc_chk u_sbc_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
